[rtl/shortest_remaining_time_scheduler_top_macros.svh]
// Assertion macros shared by the scheduler checker.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_TOP_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_TOP_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/srts_pkg.sv]
// Shared types, codes and defaults of the shortest-remaining-time scheduler.
// Depends on nothing.
package srts_pkg;

  localparam int DEF_MAX_PROCS = 16;
  localparam int DEF_TIME_BITS = 16;
  localparam int REM_W         = 16;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [1:0] STAT_RAN    = 2'd0;
  localparam logic [1:0] STAT_IDLE   = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  proc_slot;
    logic [15:0] svc_ticks;
  } srts_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  run_slot;
    logic        finished;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
  } srts_rsp_t;

  typedef struct packed {
    logic rem_we;
    logic stamp_we;
    logic occ_set;
    logic occ_clr;
  } srts_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_COMMIT
  } srts_state_t;

endpackage

[rtl/srts_slot_mem.sv]
// Per-slot storage: remaining ticks, arrival stamps and occupancy flags.
// Depends on srts_pkg.
module srts_slot_mem
  import srts_pkg::*;
#(
  parameter int MAX_PROCS = DEF_MAX_PROCS,
  parameter int TIME_BITS = DEF_TIME_BITS,
  localparam int IDX_W = $clog2(MAX_PROCS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srts_wr_t             wr,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [REM_W-1:0]     wr_rem,
  input  logic [TIME_BITS-1:0] wr_stamp,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [REM_W-1:0]     rd_rem,
  output logic [TIME_BITS-1:0] rd_stamp,
  output logic [MAX_PROCS-1:0] occ
);

  logic [REM_W-1:0]     rem_mem   [MAX_PROCS];
  logic [TIME_BITS-1:0] stamp_mem [MAX_PROCS];

  always_ff @(posedge clk) begin
    if (wr.rem_we) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    rd_rem <= rem_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_stamp <= stamp_mem[rd_addr];
  end

  // Occupancy stands in for "remaining is nonzero", so no clearing pass is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (wr.occ_set) begin
      occ[wr_addr] <= 1'b1;
    end else if (wr.occ_clr) begin
      occ[wr_addr] <= 1'b0;
    end
  end

endmodule

[rtl/shortest_remaining_time_scheduler_top.sv]
// Shortest-remaining-time-first scheduler: top level with sequencer and compare unit.
// Depends on srts_pkg and srts_slot_mem.
//
// Preemptive shortest-remaining-time-first scheduler over MAX_PROCS process
// slots. An arrival item (req_type 0) loads a free slot with its service time
// and stamps the current tick count; it gives no result unless it is rejected
// (slot busy, slot out of range or zero service time), which returns status 2.
// A tick item (req_type 1) advances the wrapping tick counter and runs the
// occupied slot with the least remaining time, lowest index on ties, for one
// tick; the result gives the slot and, on completion, the finish time and the
// turnaround. With no slot occupied the result is an idle tick (status 1).
// Items are taken one at a time: req_stall is high from the cycle after an
// accept until the item is done. A tick is accepted, then every slot is read
// in turn through the single read port of the remaining-time memory into one
// shared comparator; then the last slot is compared, the winner's arrival
// stamp is fetched, and the block writes back and loads the result. A result
// that is still stalled on the output holds the sequencer only when the next
// result is ready to load.
// The block needs no clearing pass after reset: a flip-flop per slot marks it
// occupied.
module shortest_remaining_time_scheduler_top
  import srts_pkg::*;
#(
  parameter int MAX_PROCS = DEF_MAX_PROCS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  srts_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output srts_rsp_t rsp
);

  localparam int IDX_W = $clog2(MAX_PROCS);

  srts_state_t state, state_next;

  srts_req_t            req_q;
  logic [IDX_W-1:0]     scan_idx;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [REM_W-1:0]     best_rem;
  logic [TIME_BITS-1:0] tick;

  // Sequencer controls
  logic       accept;
  logic       scan_step;
  logic       scan_issue;
  logic       do_commit;
  logic       rsp_load;
  srts_rsp_t  rsp_next;
  logic       out_free;

  // Memory port
  srts_wr_t             wr;
  logic [IDX_W-1:0]     wr_addr;
  logic [REM_W-1:0]     wr_rem;
  logic [IDX_W-1:0]     rd_addr;
  logic [REM_W-1:0]     rd_rem;
  logic [TIME_BITS-1:0] rd_stamp;
  logic [MAX_PROCS-1:0] occ;

  // Arrival decode
  logic [IDX_W-1:0]     slot_idx;
  logic                 reject;

  // Commit arithmetic
  logic [REM_W-1:0]     rem_dec;
  logic [TIME_BITS-1:0] tick_inc;
  logic [TIME_BITS-1:0] tat;
  logic                 better;

  srts_slot_mem #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_rem   (wr_rem),
    .wr_stamp (tick),
    .rd_addr  (rd_addr),
    .rd_rem   (rd_rem),
    .rd_stamp (rd_stamp),
    .occ      (occ)
  );

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Slots at or beyond MAX_PROCS cannot be loaded; the truncated index is
  // only trusted when the slot is in range.
  assign slot_idx = IDX_W'(req_q.proc_slot);
  assign reject   = (32'(req_q.proc_slot) >= 32'(MAX_PROCS)) ||
                    (req_q.svc_ticks == '0) || occ[slot_idx];

  assign rem_dec  = best_rem - REM_W'(1);
  assign tick_inc = tick + TIME_BITS'(1);
  assign tat      = tick_inc - rd_stamp;

  // Shared comparator: keep the first occupied slot with strictly less time.
  assign better = cmp_vld && occ[cmp_idx] && (!found || (rd_rem < best_rem));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    scan_step  = 1'b0;
    scan_issue = 1'b0;
    do_commit  = 1'b0;
    rsp_load   = 1'b0;
    rsp_next   = '0;
    wr         = '0;
    wr_addr    = best_idx;
    wr_rem     = rem_dec;
    rd_addr    = best_idx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_TICK) ? ST_SCAN : ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        wr_addr = slot_idx;
        wr_rem  = req_q.svc_ticks;
        if (reject) begin
          if (out_free) begin
            rsp_load          = 1'b1;
            rsp_next.status   = STAT_REJECT;
            rsp_next.run_slot = req_q.proc_slot;
            state_next        = ST_IDLE;
          end
        end else begin
          wr.rem_we   = 1'b1;
          wr.stamp_we = 1'b1;
          wr.occ_set  = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_addr    = scan_idx;
        scan_issue = 1'b1;
        if (scan_idx == IDX_W'(MAX_PROCS - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          scan_step = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          do_commit  = 1'b1;
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
          if (found) begin
            wr.rem_we         = 1'b1;
            wr.occ_clr        = (rem_dec == '0);
            rsp_next.status   = STAT_RAN;
            rsp_next.run_slot = 4'(best_idx);
            if (rem_dec == '0) begin
              rsp_next.finished    = 1'b1;
              rsp_next.finish_time = 16'(tick_inc);
              rsp_next.turnaround  = 16'(tat);
            end
          end else begin
            rsp_next.status = STAT_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Latch the item; its payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // Walk the slots and track the best candidate.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
      found    <= 1'b0;
    end else begin
      cmp_vld <= scan_issue;
      if (accept) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (scan_step) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        if (better) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (better) begin
      best_idx <= cmp_idx;
      best_rem <= rd_rem;
    end
  end

  // Advance time on every committed tick, idle or not.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (do_commit) begin
      tick <= tick_inc;
    end
  end

  // Output register: hold until taken, reload only when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

[rtl/srts_checker.sv]
// Port-level checks for the scheduler, bound to the top level.
// Depends on srts_pkg and shortest_remaining_time_scheduler_top_macros.svh.
`include "shortest_remaining_time_scheduler_top_macros.svh"

module srts_checker
  import srts_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input srts_req_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input srts_rsp_t rsp
);

  // A stalled request item holds.
  `SRTS_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req), "request changed while stalled")

  // A stalled result holds.
  `SRTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

  // One item at a time: busy right after an accept.
  `SRTS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted two items back to back")

  // No result can appear in the cycle after an accept.
  `SRTS_ASSERT_NEXT(a_no_instant_rsp, req_valid && !req_stall, !$rose(rsp_valid), "result appeared too early")

  // Only a completed run carries finish data.
  `SRTS_ASSERT_NOW(a_finish_only_ran, rsp_valid && rsp.finished, rsp.status == STAT_RAN, "finished set outside a run")

endmodule

bind shortest_remaining_time_scheduler_top srts_checker u_srts_checker (.*);
